// ===== rtl/mbo_pkg.sv =====
// Shared types, constants and bar arithmetic for the minute bar OHLCV table.
// No dependencies; imported by mbo_bar_ram and minute_bar_ohlcv_table_core.
package mbo_pkg;

    localparam int PRICE_W          = 31;
    localparam int VOL_W            = 32;
    localparam int IDX_W            = 11;
    localparam int CNT_W            = 12;
    localparam int CFG_W            = 12;
    localparam int SPAN_W           = 13;   // holds slot numbers up to 4096
    localparam int HOURS_PER_DAY    = 24;
    localparam int MINUTES_PER_HOUR = 60;
    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(HOURS_PER_DAY * MINUTES_PER_HOUR);

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef struct packed {
        logic               opcode;
        logic [IDX_W-1:0]   minute_index;
        logic [PRICE_W-1:0] price;
        logic [VOL_W-1:0]   volume;
        logic [CNT_W-1:0]   bar_count;
    } in_beat_t;

    typedef struct packed {
        logic               hit;
        logic [PRICE_W-1:0] open_out;
        logic [PRICE_W-1:0] high_out;
        logic [PRICE_W-1:0] low_out;
        logic [PRICE_W-1:0] close_out;
        logic [VOL_W-1:0]   volume_sum;
    } out_beat_t;

    typedef struct packed {
        logic [PRICE_W-1:0] bar_open;
        logic [PRICE_W-1:0] bar_high;
        logic [PRICE_W-1:0] bar_low;
        logic [PRICE_W-1:0] bar_close;
        logic [VOL_W-1:0]   bar_volume;
    } bar_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TICK_RD,
        ST_TICK_WR,
        ST_Q_SET,
        ST_Q_RUN,
        ST_DONE
    } state_t;

    function automatic logic [VOL_W-1:0] sat_add(input logic [VOL_W-1:0] a,
                                                 input logic [VOL_W-1:0] b);
        logic [VOL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VOL_W] ? {VOL_W{1'b1}} : s[VOL_W-1:0];
    endfunction

    // Apply one trade to a bar; zero price only adds volume.
    function automatic bar_t tick_update(input bar_t b,
                                         input logic [PRICE_W-1:0] price,
                                         input logic [VOL_W-1:0] vol);
        bar_t r;
        r = b;
        r.bar_volume = sat_add(b.bar_volume, vol);
        if (price != '0) begin
            if (b.bar_open == '0) r.bar_open = price;
            r.bar_close = price;
            if (b.bar_high == '0 || price > b.bar_high) r.bar_high = price;
            if (b.bar_low == '0 || price < b.bar_low) r.bar_low = price;
        end
        return r;
    endfunction

    // Fold the next bar of a range into the running merge.
    function automatic bar_t merge_bar(input bar_t acc, input bar_t b);
        bar_t r;
        r = acc;
        if (acc.bar_open == '0 && b.bar_open != '0) r.bar_open = b.bar_open;
        if (b.bar_close != '0) r.bar_close = b.bar_close;
        if (b.bar_high > acc.bar_high) r.bar_high = b.bar_high;
        if (b.bar_low != '0 && (acc.bar_low == '0 || b.bar_low < acc.bar_low))
            r.bar_low = b.bar_low;
        r.bar_volume = sat_add(acc.bar_volume, b.bar_volume);
        return r;
    endfunction

endpackage

// ===== rtl/mbo_bar_ram.sv =====
// Bar storage: one write port, one read port, registered read data.
// Depends on mbo_pkg for bar_t.
module mbo_bar_ram
    import mbo_pkg::*;
#(
    parameter int DEPTH = 2048,
    parameter int AW    = 11
) (
    input  logic          aclk,
    input  logic          wr_en,
    input  logic [AW-1:0] wr_addr,
    input  bar_t          wr_data,
    input  logic          rd_en,
    input  logic [AW-1:0] rd_addr,
    output bar_t          rd_data
);

    bar_t mem [DEPTH];
    bar_t rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== rtl/minute_bar_ohlcv_table_core.sv =====
// Top level of the minute bar OHLCV table: sequencer, merge accumulator, config.
// Depends on mbo_pkg and mbo_bar_ram.
//
// Usage:
//  - s_valid/s_ready/s_data take one item per beat: a tick (opcode 0) updates
//    one minute bar, a query (opcode 1) merges a run of bars.
//  - m_valid/m_ready/m_data return exactly one result per item, in order.
//  - cfg_wr_en/cfg_wr_data write minutes_in_use (reset 1440); write it only
//    while the block is idle. The slot limit is min(register, TABLE_DEPTH).
//  - After reset the table is cleared by a pass over all TABLE_DEPTH entries,
//    one entry a cycle; s_ready stays low until it ends.
//  - Items are handled one at a time through the bar RAM's single read and
//    write port. A tick goes from accept through read, modify and write back
//    to the result state before the next accept. A query sets up its window,
//    then walks the bars merged, reading one bar per cycle, then gives its result.
//    Out-of-range items go straight from accept to the result state.
//  - The result sits in an output register; the next item is accepted while
//    it waits. If the receiver stalls, the following item completes and then
//    waits for that register to drain.
module minute_bar_ohlcv_table_core
    import mbo_pkg::*;
#(
    parameter int TABLE_DEPTH = 2048
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  in_beat_t         s_data,
    output logic             m_valid,
    input  logic             m_ready,
    output out_beat_t        m_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam logic [SPAN_W-1:0] DEPTH_SPAN = SPAN_W'(TABLE_DEPTH);
    localparam logic [AW-1:0]     LAST_ADDR  = AW'(TABLE_DEPTH - 1);

    state_t state_reg, state_next;

    logic [CFG_W-1:0]  cfg_reg;
    in_beat_t          item_reg, item_next;
    logic              hit_reg, hit_next;
    logic [SPAN_W-1:0] lim_reg, lim_next;
    logic [SPAN_W-1:0] ptr_reg, ptr_next;
    logic [SPAN_W-1:0] end_reg, end_next;
    logic              pend_reg, pend_next;
    logic [AW-1:0]     clr_reg, clr_next;
    bar_t              acc_reg, acc_next;
    logic              out_valid_reg, out_valid_next;
    out_beat_t         out_reg, out_next;

    // Slot limit and range test for the incoming beat
    logic [SPAN_W-1:0] cfg_span;
    logic [SPAN_W-1:0] limit;
    logic [SPAN_W-1:0] in_idx;
    logic              in_hit;
    logic              accept;

    // Query window
    logic [SPAN_W-1:0] item_idx;
    logic [SPAN_W-1:0] remain;
    logic [SPAN_W-1:0] count_span;
    logic              rd_go;
    logic              out_free;

    // RAM port
    logic          ram_wr_en;
    logic [AW-1:0] ram_wr_addr;
    bar_t          ram_wr_data;
    logic          ram_rd_en;
    logic [AW-1:0] ram_rd_addr;
    bar_t          ram_rd_data;

    assign cfg_span   = SPAN_W'(cfg_reg);
    assign limit      = (cfg_span > DEPTH_SPAN) ? DEPTH_SPAN : cfg_span;
    assign in_idx     = SPAN_W'(s_data.minute_index);
    assign in_hit     = in_idx < limit;
    assign accept     = s_valid && s_ready;

    assign item_idx   = SPAN_W'(item_reg.minute_index);
    assign remain     = lim_reg - item_idx;   // item_idx < lim_reg on a hit
    assign count_span = SPAN_W'(item_reg.bar_count);
    assign rd_go      = ptr_reg < end_reg;
    assign out_free   = !out_valid_reg || m_ready;

    mbo_bar_ram #(
        .DEPTH (TABLE_DEPTH),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_en   (ram_rd_en),
        .rd_addr (ram_rd_addr),
        .rd_data (ram_rd_data)
    );

    // Next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_CLEAR: begin
                if (clr_reg == LAST_ADDR) state_next = ST_IDLE;
            end
            ST_IDLE: begin
                if (accept) begin
                    if (!in_hit)                      state_next = ST_DONE;
                    else if (s_data.opcode == OP_TICK) state_next = ST_TICK_RD;
                    else                              state_next = ST_Q_SET;
                end
            end
            ST_TICK_RD: state_next = ST_TICK_WR;
            ST_TICK_WR: state_next = ST_DONE;
            ST_Q_SET:   state_next = ST_Q_RUN;
            ST_Q_RUN: begin
                if (!rd_go && !pend_reg) state_next = ST_DONE;
            end
            ST_DONE: begin
                if (out_free) state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Outputs and datapath
    always_comb begin
        s_ready        = 1'b0;
        ram_wr_en      = 1'b0;
        ram_wr_addr    = item_idx[AW-1:0];
        ram_wr_data    = tick_update(ram_rd_data, item_reg.price, item_reg.volume);
        ram_rd_en      = 1'b0;
        ram_rd_addr    = item_idx[AW-1:0];
        item_next      = item_reg;
        hit_next       = hit_reg;
        lim_next       = lim_reg;
        ptr_next       = ptr_reg;
        end_next       = end_reg;
        pend_next      = 1'b0;
        clr_next       = clr_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && !m_ready;
        out_next       = out_reg;

        unique case (state_reg)
            ST_CLEAR: begin
                ram_wr_en   = 1'b1;
                ram_wr_addr = clr_reg;
                ram_wr_data = '0;
                clr_next    = clr_reg + AW'(1);
            end
            ST_IDLE: begin
                s_ready = 1'b1;
                if (accept) begin
                    item_next = s_data;
                    hit_next  = in_hit;
                    lim_next  = limit;
                end
            end
            ST_TICK_RD: begin
                ram_rd_en = 1'b1;
            end
            ST_TICK_WR: begin
                // read data of this bar landed on the last edge
                ram_wr_en = 1'b1;
            end
            ST_Q_SET: begin
                ptr_next = item_idx;
                acc_next = '0;
                if (count_span != '0 && count_span < remain) end_next = item_idx + count_span;
                else                                         end_next = lim_reg;
            end
            ST_Q_RUN: begin
                // one read issued per cycle while rd_go, merged in the next cycle
                ram_rd_en   = rd_go;
                ram_rd_addr = ptr_reg[AW-1:0];
                pend_next   = rd_go;
                if (rd_go) ptr_next = ptr_reg + SPAN_W'(1);
                if (pend_reg) acc_next = merge_bar(acc_reg, ram_rd_data);
            end
            ST_DONE: begin
                if (out_free) begin
                    out_valid_next = 1'b1;
                    out_next       = '0;
                    out_next.hit   = hit_reg;
                    if (hit_reg && item_reg.opcode == OP_QUERY) begin
                        out_next.open_out   = acc_reg.bar_open;
                        out_next.high_out   = acc_reg.bar_high;
                        out_next.low_out    = acc_reg.bar_low;
                        out_next.close_out  = acc_reg.bar_close;
                        out_next.volume_sum = acc_reg.bar_volume;
                    end
                end
            end
            default: ;
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            cfg_reg       <= CFG_RESET;
            clr_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) cfg_reg <= cfg_wr_data;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        item_reg <= item_next;
        hit_reg  <= hit_next;
        lim_reg  <= lim_next;
        ptr_reg  <= ptr_next;
        end_reg  <= end_next;
        acc_reg  <= acc_next;
        out_reg  <= out_next;
    end

    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

endmodule

// ===== tb/sv/minute_bar_checker.sv =====
// Self-checking monitor for the minute bar OHLCV table: keeps its own bar
// table, predicts one result per accepted input beat and compares results in order.
// Depends on mbo_pkg for the beat types and widths.
module minute_bar_checker
    import mbo_pkg::*;
#(
    parameter int TABLE_DEPTH = 2048
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  logic             s_ready,
    input  in_beat_t         s_data,
    input  logic             m_valid,
    input  logic             m_ready,
    input  out_beat_t        m_data,
    input  logic             cfg_wr_en,
    input  logic [CFG_W-1:0] cfg_wr_data,
    output int               mismatches,
    output int               outstanding,
    output int               results_seen
);
    timeunit 1ns;
    timeprecision 1ps;

    bar_t             bars [TABLE_DEPTH];
    logic [CFG_W-1:0] minutes_reg;
    out_beat_t        expected_bars [$];
    int               mismatch_cnt;
    int               result_cnt;

    function automatic logic [VOL_W-1:0] vol_add(input logic [VOL_W-1:0] a,
                                                 input logic [VOL_W-1:0] b);
        logic [VOL_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[VOL_W] ? {VOL_W{1'b1}} : s[VOL_W-1:0];
    endfunction

    // Updates the shadow table for a trade; merges a run of bars for a query.
    function automatic out_beat_t predict_bar(input in_beat_t it);
        int unsigned lim;
        int unsigned last;
        int unsigned i;
        out_beat_t   r;
        bar_t        b;
        lim = (minutes_reg > TABLE_DEPTH) ? TABLE_DEPTH : minutes_reg;
        r = '0;
        r.hit = (it.minute_index < lim);
        if (!r.hit) return r;
        if (it.opcode == OP_TICK) begin
            b = bars[it.minute_index];
            b.bar_volume = vol_add(b.bar_volume, it.volume);
            if (it.price != '0) begin
                if (b.bar_open == '0) b.bar_open = it.price;
                b.bar_close = it.price;
                if (b.bar_high == '0 || it.price > b.bar_high) b.bar_high = it.price;
                if (b.bar_low == '0 || it.price < b.bar_low) b.bar_low = it.price;
            end
            bars[it.minute_index] = b;
        end else begin
            last = lim;
            if (it.bar_count != '0 && it.bar_count < lim - it.minute_index)
                last = it.minute_index + it.bar_count;
            for (i = it.minute_index; i < last; i++) begin
                b = bars[i];
                if (r.open_out == '0 && b.bar_open != '0) r.open_out = b.bar_open;
                if (b.bar_close != '0) r.close_out = b.bar_close;
                if (b.bar_high > r.high_out) r.high_out = b.bar_high;
                if (b.bar_low != '0 && (r.low_out == '0 || b.bar_low < r.low_out))
                    r.low_out = b.bar_low;
                r.volume_sum = vol_add(r.volume_sum, b.bar_volume);
            end
        end
        return r;
    endfunction

    function automatic bit fields_match(input out_beat_t want, input out_beat_t got);
        return (got.hit === want.hit) && (got.open_out === want.open_out) &&
               (got.high_out === want.high_out) && (got.low_out === want.low_out) &&
               (got.close_out === want.close_out) && (got.volume_sum === want.volume_sum);
    endfunction

    always @(posedge aclk) begin
        out_beat_t want;
        if (!aresetn) begin
            minutes_reg = CFG_RESET;
            foreach (bars[k]) bars[k] = '0;
            expected_bars.delete();
            mismatch_cnt = 0;
            result_cnt   = 0;
        end else begin
            if (cfg_wr_en) minutes_reg = cfg_wr_data;
            if (s_valid && s_ready) expected_bars.push_back(predict_bar(s_data));
            if (m_valid && m_ready) begin
                result_cnt++;
                if (expected_bars.size() == 0) begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("[%0t] unexpected result beat: hit=%0d o=%h h=%h l=%h c=%h v=%h",
                                 $realtime, m_data.hit, m_data.open_out, m_data.high_out,
                                 m_data.low_out, m_data.close_out, m_data.volume_sum);
                end else begin
                    want = expected_bars.pop_front();
                    if (!fields_match(want, m_data)) begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10) begin
                            $display("[%0t] result %0d mismatch, exp hit=%0d o=%h h=%h l=%h c=%h v=%h",
                                     $realtime, result_cnt, want.hit, want.open_out,
                                     want.high_out, want.low_out, want.close_out,
                                     want.volume_sum);
                            $display("    got hit=%0d o=%h h=%h l=%h c=%h v=%h",
                                     m_data.hit, m_data.open_out, m_data.high_out,
                                     m_data.low_out, m_data.close_out, m_data.volume_sum);
                        end
                    end
                end
            end
        end
        outstanding  <= expected_bars.size();
        mismatches   <= mismatch_cnt;
        results_seen <= result_cnt;
    end

endmodule

// ===== tb/sv/tb_minute_bar_ohlcv_table_core.sv =====
// Top of the minute bar OHLCV table testbench: clock, reset, stimulus and verdict.
// Depends on mbo_pkg, minute_bar_ohlcv_table_core and minute_bar_checker.
module tb_minute_bar_ohlcv_table_core
    import mbo_pkg::*;
();
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          TABLE_DEPTH = 2048;
    localparam int unsigned CYCLE_LIMIT = 5_000_000;  // far above the slowest legal run
    localparam int          HOLD_CYCLES = 400;        // long receiver stall

    logic             aclk        = 1'b0;
    logic             aresetn     = 1'b0;
    logic             s_valid     = 1'b0;
    in_beat_t         s_data      = '0;
    logic             m_ready     = 1'b0;
    logic             cfg_wr_en   = 1'b0;
    logic [CFG_W-1:0] cfg_wr_data = '0;
    logic             s_ready;
    logic             m_valid;
    out_beat_t        m_data;

    int mismatches;
    int outstanding;
    int results_seen;

    // Idle odds in percent; sender's is used by the stimulus process only.
    int send_idle_pct = 0;
    int recv_idle_pct = 0;

    // Long stall handshake between stimulus and receiver processes.
    int hold_requests = 0;
    int holds_done    = 0;
    int hold_left     = 0;

    int          ticks_sent    = 0;
    int          queries_sent  = 0;
    int          settings_used = 1;   // reset value counts as the first
    int unsigned cycle_cnt     = 0;

    // Stimulus shaping: effective slot count and a hot window of bars.
    int unsigned cur_limit = 1440;
    int unsigned hot_base  = 0;

    always #4 aclk = ~aclk;

    minute_bar_ohlcv_table_core #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) dut (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_data     (m_data),
        .cfg_wr_en  (cfg_wr_en),
        .cfg_wr_data(cfg_wr_data)
    );

    minute_bar_checker #(
        .TABLE_DEPTH(TABLE_DEPTH)
    ) u_bar_check (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_data      (s_data),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_data      (m_data),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .results_seen(results_seen)
    );

    // Watchdog: a hung handshake ends the run here.
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d beats still expected", cycle_cnt,
                     outstanding);
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    // Result side: random back-pressure, plus a long hold when one is requested.
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (holds_done < hold_requests) begin
            m_ready    <= 1'b0;
            hold_left  <= HOLD_CYCLES;
            holds_done <= holds_done + 1;
        end else begin
            m_ready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    task automatic set_idling(input int send_pct, input int recv_pct);
        send_idle_pct = send_pct;
        recv_idle_pct <= recv_pct;
    endtask

    // Offer one beat and hold it until accepted. Valid is not dropped between
    // back-to-back beats; here it only falls when an idle gap is inserted.
    // Each cycle the sender could offer, it idles with send_idle_pct odds.
    task automatic send_beat(input in_beat_t beat);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= beat;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (beat.opcode == OP_TICK) ticks_sent++;
        else queries_sent++;
    endtask

    // outstanding is registered in the monitor, so the value read is from the cycle before;
    // the leading edge wait keeps the last accepted beat from being missed.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (outstanding != 0);
    endtask

    // Register writes happen only with nothing in flight.
    task automatic write_minutes(input logic [CFG_W-1:0] value);
        wait_drained();
        cfg_wr_en   <= 1'b1;
        cfg_wr_data <= value;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        cur_limit = (value > TABLE_DEPTH) ? TABLE_DEPTH : value;
        hot_base  = (cur_limit > 32) ? $urandom_range(0, cur_limit - 32) : 0;
        settings_used++;
    endtask

    function automatic in_beat_t mk(input logic op, input int unsigned idx,
                                    input int unsigned price,
                                    input int unsigned vol,
                                    input int unsigned cnt);
        in_beat_t b;
        b.opcode       = op;
        b.minute_index = IDX_W'(idx);
        b.price        = PRICE_W'(price);
        b.volume       = VOL_W'(vol);
        b.bar_count    = CNT_W'(cnt);
        return b;
    endfunction

    // Mostly trades and queries on a small hot window so merges see real bars;
    // the rest lands on the range edges or anywhere in the index space.
    function automatic in_beat_t pick_beat();
        in_beat_t    b;
        int unsigned span;
        int unsigned r;
        span = (cur_limit == 0 || cur_limit > 32) ? 32 : cur_limit;
        b.opcode = ($urandom_range(99) < 65) ? OP_TICK : OP_QUERY;

        r = $urandom_range(99);
        if (r < 80)      b.minute_index = IDX_W'(hot_base + $urandom_range(0, span - 1));
        else if (r < 90) b.minute_index = IDX_W'($urandom);
        else             b.minute_index = IDX_W'(cur_limit + $urandom_range(0, 1) - 1);

        r = $urandom_range(99);
        if (r < 10)      b.price = '0;
        else if (r < 15) b.price = '1;
        else if (r < 35) b.price = PRICE_W'($urandom);
        else             b.price = PRICE_W'(1000 + $urandom_range(0, 500));

        r = $urandom_range(99);
        if (r < 5)       b.volume = '0;
        else if (r < 10) b.volume = '1;
        else if (r < 15) b.volume = '1 - VOL_W'($urandom_range(0, 1000));
        else if (r < 30) b.volume = $urandom;
        else             b.volume = VOL_W'($urandom_range(1, 100000));

        // Walk lengths stay short most of the time; long walks are the slow path.
        r = $urandom_range(99);
        if (b.opcode == OP_TICK) b.bar_count = CNT_W'($urandom);
        else if (r < 55) b.bar_count = CNT_W'($urandom_range(1, 40));
        else if (r < 65) b.bar_count = '0;
        else if (r < 75) b.bar_count = CNT_W'($urandom_range(0, 4095));
        else if (r < 85) b.bar_count = ($urandom_range(1)) ? '1 : CNT_W'(TABLE_DEPTH);
        else             b.bar_count = CNT_W'(cur_limit - b.minute_index);
        return b;
    endfunction

    task automatic run_random(input int n);
        repeat (n) send_beat(pick_beat());
    endtask

    initial begin
        set_idling(29, 60);
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed beats at the reset slot count of 1440.
        send_beat(mk(OP_QUERY, 0, 0, 0, 0));               // empty table, full walk
        send_beat(mk(OP_TICK, 0, 100, 5, 0));              // first trade sets all four prices
        send_beat(mk(OP_TICK, 0, 0, 7, 0));                // zero price: volume only
        send_beat(mk(OP_TICK, 0, 50, 1, 0));               // new low
        send_beat(mk(OP_TICK, 0, 200, 1, 0));              // new high
        send_beat(mk(OP_TICK, 0, '1, '1, 0));              // max price, volume saturates
        send_beat(mk(OP_TICK, 0, 1, '1, 0));               // stays saturated
        send_beat(mk(OP_TICK, 2, 300, 10, 0));
        send_beat(mk(OP_TICK, 1, 0, 3, 0));                // bar with volume but no prices
        send_beat(mk(OP_TICK, 1439, 77, 2, 0));            // last slot in use
        send_beat(mk(OP_TICK, 1440, 88, 2, 0));            // first slot out of range
        send_beat(mk(OP_TICK, 2047, '1, '1, '1));          // top index, all fields high
        send_beat(mk(OP_QUERY, 0, 0, 0, 3));
        send_beat(mk(OP_QUERY, 1, 0, 0, 2));               // leading bar has no open
        send_beat(mk(OP_QUERY, 1, 0, 0, 1));               // price-less bar alone
        send_beat(mk(OP_QUERY, 1438, 0, 0, 4095));         // count runs past the end
        send_beat(mk(OP_QUERY, 1439, 0, 0, 0));
        send_beat(mk(OP_QUERY, 1440, 0, 0, 1));            // out of range query
        send_beat(mk(OP_QUERY, 2047, '1, '1, 4095));
        send_beat(mk(OP_QUERY, 0, 0, 0, 1440));            // exactly to the end
        send_beat(mk(OP_QUERY, 0, 0, 0, 2048));
        send_beat(mk(OP_TICK, 1439, '1, '1, 0));
        send_beat(mk(OP_QUERY, 0, 0, 0, 0));               // merged volume saturates
        run_random(70);

        // Above the table depth: clamps to the full table. The receiver stalls
        // long while beats keep coming, so the block backs up and drops s_ready.
        write_minutes(CFG_W'(4095));
        hold_requests <= hold_requests + 1;
        run_random(70);

        set_idling(60, 29);
        write_minutes(CFG_W'(0));                          // every slot out of range
        run_random(20);
        write_minutes(CFG_W'(1));                          // smallest legal table
        run_random(40);
        write_minutes(CFG_W'(100));
        run_random(40);
        wait_drained();                                    // sender pause with nothing in flight
        run_random(40);

        set_idling(0, 0);
        write_minutes(CFG_W'(TABLE_DEPTH));                // old bars above 100 show again
        run_random(80);
        write_minutes(CFG_W'(1440));
        run_random(40);

        wait_drained();
        repeat (50) @(posedge aclk);

        $display("Covered %0d trades and %0d range queries over %0d slot-count settings,",
                 ticks_sent, queries_sent, settings_used);
        $display("with %0d result beats compared under mixed and long back-pressure.",
                 results_seen);
        if (mismatches == 0 && outstanding == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/mbo_pkg.sv
rtl/mbo_bar_ram.sv
rtl/minute_bar_ohlcv_table_core.sv
tb/sv/minute_bar_checker.sv
tb/sv/tb_minute_bar_ohlcv_table_core.sv
